// ----- hdl/bn_pkg.sv -----
package bn_pkg;

  // Command codes of an input beat.
  localparam logic [2:0] CMD_SCALE  = 3'd0;
  localparam logic [2:0] CMD_SHIFT  = 3'd1;
  localparam logic [2:0] CMD_MEAN   = 3'd2;
  localparam logic [2:0] CMD_VAR    = 3'd3;
  localparam logic [2:0] CMD_SAMPLE = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_EPS  = 2'd1;
  localparam logic [1:0] CFG_MOM  = 2'd2;

  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [16:0] EPS_RST   = 17'd1;
  localparam logic [16:0] MOM_RST   = 17'd6554;

  // Shared divider and root widths.
  localparam int DIV_W = 56;
  localparam int DSR_W = 24;
  localparam int RAD_W = 48;
  localparam int ROOT_W = 24;

  typedef struct packed {
    logic [2:0]         command;
    logic [5:0]         channel;
    logic signed [31:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] normalized;
    logic [5:0]         out_channel;
    logic               out_last;
    logic signed [31:0] new_running_mean;
    logic [30:0]        new_running_variance;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_TBL_WRITE,
    OP_PUSH,
    OP_MEAN_START,
    OP_MEAN_DONE,
    OP_V_DIFF,
    OP_V_SQ,
    OP_V_ACC,
    OP_VDIV_START,
    OP_VDIV_DONE,
    OP_BLEND_MUL,
    OP_BLEND_SUM,
    OP_INF_SETUP,
    OP_SQRT_START,
    OP_INV_START,
    OP_INV_DONE,
    OP_INV_SAT,
    OP_N_DIFF,
    OP_N_MUL1,
    OP_N_XH,
    OP_N_MUL2,
    OP_N_OUT,
    OP_BATCH_END
  } op_t;

  typedef struct packed {
    op_t op;
  } bn_cmd_t;

  typedef struct packed {
    logic ignore;
    logic is_table;
    logic training;
    logic last;
    logic cnt_zero;
    logic k_last;
    logic div_done;
    logic sqrt_done;
    logic rad_zero;
    logic out_busy;
    logic batch;
  } bn_status_t;

endpackage

// ----- hdl/bn_ram.sv -----
module bn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/bn_div.sv -----
module bn_div import bn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quot,
  output logic [DSR_W-1:0] rem
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [DSR_W-1:0] dsr;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DSR_W:0]   sh;
  logic             fits;

  // One quotient bit a cycle, restoring form.
  assign sh   = {rem, quot[DIV_W-1]};
  assign fits = sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(DIV_W);
      quot <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      quot <= {quot[DIV_W-2:0], fits};
      rem  <= fits ? DSR_W'(sh - {1'b0, dsr}) : sh[DSR_W-1:0];
      cnt  <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ----- hdl/bn_sqrt.sv -----
module bn_sqrt import bn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  rad,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CW = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0] v;
  logic [RAD_W:0]   res;
  logic [RAD_W-1:0] bitv;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [RAD_W:0]   trial;

  assign trial = res + {1'b0, bitv};
  assign root  = res[ROOT_W-1:0];

  // Digit-by-digit root, one result bit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(ROOT_W);
      v    <= rad;
      res  <= '0;
      bitv <= RAD_W'(1) << (RAD_W - 2);
    end else if (busy) begin
      if ({1'b0, v} >= trial) begin
        v   <= RAD_W'({1'b0, v} - trial);
        res <= (res >> 1) + {1'b0, bitv};
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ----- hdl/bn_ctrl.sv -----
module bn_ctrl import bn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  bn_status_t st,
  output bn_cmd_t    cmd,
  output logic       idle
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_B_CHECK, S_MEAN_WAIT, S_V_ADDR, S_V_DIFF, S_V_SQ,
    S_V_ACC, S_VDIV_START, S_VDIV_WAIT, S_BLEND_MUL, S_BLEND_SUM, S_INF_SETUP,
    S_RAD, S_SQRT_WAIT, S_INV_WAIT, S_N_ADDR, S_N_DIFF, S_N_MUL1, S_N_XH,
    S_N_MUL2, S_N_OUT, S_BATCH_END
  } state_t;

  state_t state, state_next;

  assign idle = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (st.ignore) begin
          state_next = S_IDLE;
        end else if (st.is_table) begin
          cmd.op     = OP_TBL_WRITE;
          state_next = S_IDLE;
        end else if (!st.training) begin
          state_next = S_INF_SETUP;
        end else begin
          cmd.op     = OP_PUSH;
          state_next = st.last ? S_B_CHECK : S_IDLE;
        end
      end
      S_B_CHECK: begin
        if (st.cnt_zero) begin
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_MEAN_START;
          state_next = S_MEAN_WAIT;
        end
      end
      S_MEAN_WAIT: begin
        if (st.div_done) begin
          cmd.op     = OP_MEAN_DONE;
          state_next = S_V_ADDR;
        end
      end
      S_V_ADDR: state_next = S_V_DIFF;
      S_V_DIFF: begin
        cmd.op     = OP_V_DIFF;
        state_next = S_V_SQ;
      end
      S_V_SQ: begin
        cmd.op     = OP_V_SQ;
        state_next = S_V_ACC;
      end
      S_V_ACC: begin
        cmd.op     = OP_V_ACC;
        state_next = st.k_last ? S_VDIV_START : S_V_ADDR;
      end
      S_VDIV_START: begin
        cmd.op     = OP_VDIV_START;
        state_next = S_VDIV_WAIT;
      end
      S_VDIV_WAIT: begin
        if (st.div_done) begin
          cmd.op     = OP_VDIV_DONE;
          state_next = S_BLEND_MUL;
        end
      end
      S_BLEND_MUL: begin
        cmd.op     = OP_BLEND_MUL;
        state_next = S_BLEND_SUM;
      end
      S_BLEND_SUM: begin
        cmd.op     = OP_BLEND_SUM;
        state_next = S_RAD;
      end
      S_INF_SETUP: begin
        cmd.op     = OP_INF_SETUP;
        state_next = S_RAD;
      end
      S_RAD: begin
        if (st.rad_zero) begin
          cmd.op     = OP_INV_SAT;
          state_next = S_N_ADDR;
        end else begin
          cmd.op     = OP_SQRT_START;
          state_next = S_SQRT_WAIT;
        end
      end
      S_SQRT_WAIT: begin
        if (st.sqrt_done) begin
          cmd.op     = OP_INV_START;
          state_next = S_INV_WAIT;
        end
      end
      S_INV_WAIT: begin
        if (st.div_done) begin
          cmd.op     = OP_INV_DONE;
          state_next = S_N_ADDR;
        end
      end
      S_N_ADDR: state_next = S_N_DIFF;
      S_N_DIFF: begin
        cmd.op     = OP_N_DIFF;
        state_next = S_N_MUL1;
      end
      S_N_MUL1: begin
        cmd.op     = OP_N_MUL1;
        state_next = S_N_XH;
      end
      S_N_XH: begin
        cmd.op     = OP_N_XH;
        state_next = S_N_MUL2;
      end
      S_N_MUL2: begin
        cmd.op     = OP_N_MUL2;
        state_next = S_N_OUT;
      end
      S_N_OUT: begin
        if (!st.out_busy) begin
          cmd.op = OP_N_OUT;
          if (!st.batch) begin
            state_next = S_IDLE;
          end else if (st.k_last) begin
            state_next = S_BATCH_END;
          end else begin
            state_next = S_N_ADDR;
          end
        end
      end
      S_BATCH_END: begin
        cmd.op     = OP_BATCH_END;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/bn_dp.sv -----
module bn_dp import bn_pkg::*; #(
  parameter int CHANNELS    = 64,
  parameter int BATCH_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  in_item_t   item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [16:0] cfg_data,
  input  bn_cmd_t    cmd,
  output bn_status_t st,
  output logic       result_valid,
  input  logic       result_ready,
  output out_item_t  result
);

  localparam int TAW  = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
  localparam int BAW  = BATCH_DEPTH > 1 ? $clog2(BATCH_DEPTH) : 1;
  localparam int CNTW = $clog2(BATCH_DEPTH + 1);

  in_item_t           in_q;
  logic               mode;
  logic [16:0]        eps;
  logic [16:0]        mom;
  logic [CNTW-1:0]    cnt;
  logic [CNTW-1:0]    k;
  logic signed [38:0] sum;
  logic               sum_neg;
  logic [54:0]        acc;
  logic signed [31:0] nmean;
  logic [31:0]        dm;
  logic               dneg;
  logic [47:0]        sq;
  logic [30:0]        stat_var;
  logic               batch;
  logic signed [49:0] pm1, pm2, pv1, pv2;
  logic signed [31:0] out_mean;
  logic [30:0]        out_var;
  logic [40:0]        inv;
  logic [63:0]        p_lo;
  logic [40:0]        p_hi;
  logic [41:0]        xh;
  logic [63:0]        q_lo;
  logic [41:0]        q_hi;
  logic               nsign;

  logic [CHANNELS-1:0] vld_scale, vld_shift, vld_mean, vld_var;
  logic [TAW-1:0]      chan_a;
  logic [31:0]         rd_scale, rd_shift, rd_mean, rd_var, rd_buf;
  logic signed [31:0]  t_scale, t_shift, t_mean, t_var;

  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_dvd, div_q;
  logic [DSR_W-1:0]   div_dsr, div_r;
  logic               sqrt_done;
  logic [ROOT_W-1:0]  root;
  logic [31:0]        rad;

  logic [16:0]        meff, wgt;
  logic signed [50:0] bm_sum, bv_sum;
  logic signed [32:0] x_ext, dif;
  logic [37:0]        sum_mag;
  logic [32:0]        mq;
  logic [31:0]        gm;
  logic [58:0]        mag;
  logic signed [60:0] tot;
  logic signed [31:0] sat_y;
  logic               we_scale, we_shift, we_mean, we_var, we_buf;
  logic [31:0]        wd_mean, wd_var;

  assign chan_a = TAW'(in_q.channel);

  // Entries never written read as their reset values.
  assign t_scale = vld_scale[chan_a] ? rd_scale : 32'sd65536;
  assign t_shift = vld_shift[chan_a] ? rd_shift : 32'sd0;
  assign t_mean  = vld_mean[chan_a]  ? rd_mean  : 32'sd0;
  assign t_var   = vld_var[chan_a]   ? rd_var   : 32'sd65536;

  assign we_scale = cmd.op == OP_TBL_WRITE && in_q.command == CMD_SCALE;
  assign we_shift = cmd.op == OP_TBL_WRITE && in_q.command == CMD_SHIFT;
  assign we_mean  = (cmd.op == OP_TBL_WRITE && in_q.command == CMD_MEAN)
                    || cmd.op == OP_BLEND_SUM;
  assign we_var   = (cmd.op == OP_TBL_WRITE && in_q.command == CMD_VAR)
                    || cmd.op == OP_BLEND_SUM;
  assign we_buf   = cmd.op == OP_PUSH && int'(cnt) < BATCH_DEPTH;

  // Running update: floor((w*old + m*stat) / 2^16) via an arithmetic shift.
  assign meff   = mom > ONE_Q16 ? ONE_Q16 : mom;
  assign wgt    = ONE_Q16 - meff;
  assign bm_sum = 51'(pm1) + 51'(pm2);
  assign bv_sum = 51'(pv1) + 51'(pv2);

  always_comb begin
    if (cmd.op == OP_BLEND_SUM) begin
      wd_mean = bm_sum[47:16];
      wd_var  = {1'b0, bv_sum[46:16]};
    end else begin
      wd_mean = in_q.value;
      wd_var  = in_q.value[31] ? 32'd0 : in_q.value;
    end
  end

  bn_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_scale (
    .clk, .we(we_scale), .waddr(chan_a), .wdata(in_q.value), .raddr(chan_a),
    .rdata(rd_scale));
  bn_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_shift (
    .clk, .we(we_shift), .waddr(chan_a), .wdata(in_q.value), .raddr(chan_a),
    .rdata(rd_shift));
  bn_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_mean (
    .clk, .we(we_mean), .waddr(chan_a), .wdata(wd_mean), .raddr(chan_a),
    .rdata(rd_mean));
  bn_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_var (
    .clk, .we(we_var), .waddr(chan_a), .wdata(wd_var), .raddr(chan_a),
    .rdata(rd_var));
  bn_ram #(.WIDTH(32), .DEPTH(BATCH_DEPTH)) u_buf (
    .clk, .we(we_buf), .waddr(cnt[BAW-1:0]), .wdata(in_q.value),
    .raddr(k[BAW-1:0]), .rdata(rd_buf));

  // One divider serves the batch mean, the variance and the inverse root.
  assign sum_mag = sum[38] ? 38'(-sum) : 38'(sum);
  assign div_start = cmd.op == OP_MEAN_START || cmd.op == OP_VDIV_START
                     || cmd.op == OP_INV_START;
  always_comb begin
    case (cmd.op)
      OP_MEAN_START: begin
        div_dvd = DIV_W'(sum_mag);
        div_dsr = DSR_W'(cnt);
      end
      OP_VDIV_START: begin
        div_dvd = DIV_W'(acc);
        div_dsr = DSR_W'(cnt);
      end
      default: begin
        div_dvd = DIV_W'(1) << 48;
        div_dsr = root;
      end
    endcase
  end

  bn_div u_div (
    .clk, .rst, .start(div_start), .dividend(div_dvd), .divisor(div_dsr),
    .done(div_done), .quot(div_q), .rem(div_r));

  assign rad = {1'b0, stat_var} + 32'(eps);

  bn_sqrt u_sqrt (
    .clk, .rst, .start(cmd.op == OP_SQRT_START), .rad({rad, 16'd0}),
    .done(sqrt_done), .root(root));

  assign mq    = div_q[32:0] + 33'(sum_neg && div_r != '0);
  assign x_ext = batch ? 33'(signed'(rd_buf)) : 33'(in_q.value);
  assign dif   = x_ext - 33'(nmean);
  assign gm    = t_scale[31] ? 32'(-t_scale) : 32'(t_scale);
  assign mag   = {1'b0, q_hi, 16'd0} + 59'(q_lo[63:16]);
  assign tot   = (nsign ? -61'(signed'({2'b0, mag})) : 61'(signed'({2'b0, mag})))
                 + 61'(t_shift);
  assign sat_y = tot > 61'sd2147483647 ? 32'sh7FFFFFFF :
                 tot < -61'sd2147483648 ? 32'sh80000000 : tot[31:0];

  always_comb begin
    st.ignore    = int'(in_q.channel) >= CHANNELS || in_q.command > CMD_SAMPLE;
    st.is_table  = in_q.command != CMD_SAMPLE;
    st.training  = mode;
    st.last      = in_q.last;
    st.cnt_zero  = cnt == '0;
    st.k_last    = (k + 1'b1) == cnt;
    st.div_done  = div_done;
    st.sqrt_done = sqrt_done;
    st.rad_zero  = rad == '0;
    st.out_busy  = result_valid && !result_ready;
    st.batch     = batch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= 1'b0;
      eps          <= EPS_RST;
      mom          <= MOM_RST;
      cnt          <= '0;
      sum          <= '0;
      batch        <= 1'b0;
      result_valid <= 1'b0;
      vld_scale    <= '0;
      vld_shift    <= '0;
      vld_mean     <= '0;
      vld_var      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE: mode <= cfg_data[0];
          CFG_EPS:  eps  <= cfg_data;
          CFG_MOM:  mom  <= cfg_data;
          default: ;
        endcase
      end
      if (we_scale) vld_scale[chan_a] <= 1'b1;
      if (we_shift) vld_shift[chan_a] <= 1'b1;
      if (we_mean)  vld_mean[chan_a]  <= 1'b1;
      if (we_var)   vld_var[chan_a]   <= 1'b1;
      // A new result may replace one taken at the same edge.
      if (cmd.op == OP_N_OUT) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (cmd.op)
        OP_PUSH: begin
          if (we_buf) begin
            cnt <= cnt + 1'b1;
            sum <= sum + 39'(in_q.value);
          end
        end
        OP_MEAN_START: batch <= 1'b1;
        OP_INF_SETUP:  batch <= 1'b0;
        OP_BATCH_END: begin
          cnt <= '0;
          sum <= '0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= item;
    end
    case (cmd.op)
      OP_MEAN_START: sum_neg <= sum[38];
      OP_MEAN_DONE: begin
        nmean <= sum_neg ? 32'(-mq) : mq[31:0];
        k     <= '0;
        acc   <= '0;
      end
      OP_V_DIFF, OP_N_DIFF: begin
        dneg <= dif[32];
        dm   <= dif[32] ? 32'(-dif) : dif[31:0];
      end
      OP_V_SQ:  sq <= 48'((64'(dm) * 64'(dm)) >> 16);
      OP_V_ACC: begin
        acc <= acc + 55'(sq);
        k   <= k + 1'b1;
      end
      OP_VDIV_DONE: begin
        stat_var <= div_q > DIV_W'(32'h7FFFFFFF) ? 31'h7FFFFFFF : div_q[30:0];
      end
      OP_BLEND_MUL: begin
        pm1 <= 50'(signed'({1'b0, wgt})) * 50'(t_mean);
        pm2 <= 50'(signed'({1'b0, meff})) * 50'(nmean);
        pv1 <= 50'(signed'({1'b0, wgt})) * 50'(t_var);
        pv2 <= 50'(signed'({1'b0, meff})) * 50'(signed'({1'b0, stat_var}));
      end
      OP_BLEND_SUM: begin
        out_mean <= bm_sum[47:16];
        out_var  <= bv_sum[46:16];
      end
      OP_INF_SETUP: begin
        nmean    <= t_mean;
        stat_var <= t_var[30:0];
        out_mean <= t_mean;
        out_var  <= t_var[30:0];
      end
      OP_INV_DONE: begin
        inv <= div_q[40:0];
        k   <= '0;
      end
      OP_INV_SAT: begin
        inv <= 41'(1) << 40;
        k   <= '0;
      end
      OP_N_MUL1: begin
        p_lo <= 64'(dm) * 64'(inv[31:0]);
        p_hi <= 41'(dm) * 41'(inv[40:32]);
      end
      OP_N_XH: xh <= 42'(p_hi) + 42'(p_lo[63:32]);
      OP_N_MUL2: begin
        q_lo  <= 64'(gm) * 64'(xh[31:0]);
        q_hi  <= 42'(gm) * 42'(xh[41:32]);
        nsign <= dneg ^ t_scale[31];
      end
      OP_N_OUT: begin
        result.normalized           <= sat_y;
        result.out_channel          <= in_q.channel;
        result.out_last             <= !batch || st.k_last;
        result.new_running_mean     <= out_mean;
        result.new_running_variance <= out_var;
        k                           <= k + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/batch_norm_forward.sv -----
// Per-channel batch normalisation in Q16.16 fixed point.
//
// Input channel (item_valid/item_ready/item): each beat is a table load
// (scale, shift, running mean, running variance) or a sample; other command
// codes and out-of-range channels are dropped. Table loads give no result.
// In inference mode a sample gives one result: dispatch and table read,
// the square root and the division giving the inverse deviation, then
// normalisation. A zero radicand skips the root and the division. In
// training mode samples are buffered and the beat marked last starts the
// batch pass: the mean division, a variance pass over the buffered
// samples, a second division, the running update, the root and
// reciprocal, then one result per buffered sample.
//
// Output channel (result_valid/result_ready/result): a result register holds
// one beat; a stalled receiver holds the sequencer only when the next result
// is ready, and a new input beat is taken while a result waits.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data).
// A synchronous reset restores the control and configuration registers and
// marks all table entries as holding their reset values; no clearing pass is needed.
module batch_norm_forward import bn_pkg::*; #(
  parameter int CHANNELS    = 64,
  parameter int BATCH_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  in_item_t    item,
  output logic        result_valid,
  input  logic        result_ready,
  output out_item_t   result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  bn_cmd_t    cmd;
  bn_status_t st;
  logic       accept;

  // The sequencer takes a new beat only from its idle state.
  assign accept = item_valid && item_ready;

  bn_ctrl u_ctrl (
    .clk, .rst, .accept, .st, .cmd, .idle(item_ready));

  bn_dp #(.CHANNELS(CHANNELS), .BATCH_DEPTH(BATCH_DEPTH)) u_dp (
    .clk, .rst, .accept, .item, .cfg_we, .cfg_index, .cfg_data, .cmd, .st,
    .result_valid, .result_ready, .result);

endmodule

// ----- hdl/bn_checker.sv -----
module bn_props import bn_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      item_valid,
  input logic      item_ready,
  input logic      result_valid,
  input logic      result_ready,
  input out_item_t result
);

  // A held result beat keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat dropped or changed while stalled");

  // The sequencer is busy in the cycle after taking a beat.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input taken twice in a row");

  // A fresh result is only produced while the sequencer is busy.
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!item_ready))
    else $error("result appeared while idle");

  // Reset empties the result register.
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule

bind batch_norm_forward bn_props u_chk (.*);

// ----- verif/bn_checker.sv -----
module bn_checker import bn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_ready,
  input  in_item_t    item,
  input  logic        result_valid,
  input  logic        result_ready,
  input  out_item_t   result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  output int          failures,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH   = 64;
  localparam int DEPTH = 64;

  bit              train_on;
  bit [16:0]       eps_q16;
  bit [16:0]       mom_q16;
  longint          gain_tbl [NCH];
  longint          bias_tbl [NCH];
  longint          avg_tbl  [NCH];
  longint          var_tbl  [NCH];
  longint          held     [DEPTH];
  int              held_cnt;
  longint          held_sum;
  out_item_t       norm_expect_q [$];

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned inv_dev(longint variance);
    longint unsigned r, s;
    r = longint'(variance) + longint'(eps_q16);
    if (r == 0) return 64'd1 << 40;
    s = root64(r << 16);
    if (s == 0) return 64'd1 << 40;
    return (64'd1 << 48) / s;
  endfunction

  function automatic logic [31:0] norm_sample(longint x, longint mu, longint unsigned inv,
                                              longint g, longint b);
    longint          d, t;
    bit              dneg, gneg;
    longint unsigned dm, gm, xh, mag;
    logic [127:0]    p;
    d = x - mu;
    dneg = d < 0;
    gneg = g < 0;
    dm = dneg ? -d : d;
    gm = gneg ? -g : g;
    p = {64'd0, dm} * {64'd0, inv};
    xh = p[95:32];
    p = {64'd0, gm} * {64'd0, xh};
    mag = p[79:16];
    t = (dneg != gneg) ? -longint'(mag) : longint'(mag);
    t += b;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t[31:0];
  endfunction

  function automatic longint blend_running(longint old, longint stat);
    longint m;
    m = (mom_q16 > 17'd65536) ? 64'd65536 : longint'(mom_q16);
    return ((64'sd65536 - m) * old + m * stat) >>> 16;
  endfunction

  function automatic out_item_t make_result(logic [31:0] y, int ch, bit lst);
    out_item_t r;
    r.normalized           = y;
    r.out_channel          = ch[5:0];
    r.out_last             = lst;
    r.new_running_mean     = avg_tbl[ch][31:0];
    r.new_running_variance = var_tbl[ch][30:0];
    return r;
  endfunction

  task automatic predict_beat(in_item_t it);
    int              ch, n;
    longint          v, mu, q, vr;
    longint unsigned acc, dm, inv;
    ch = it.channel;
    v = longint'(it.value);
    if (it.command > CMD_SAMPLE) return;
    case (it.command)
      CMD_SCALE: gain_tbl[ch] = v;
      CMD_SHIFT: bias_tbl[ch] = v;
      CMD_MEAN:  avg_tbl[ch] = v;
      CMD_VAR:   var_tbl[ch] = (v < 0) ? 0 : v;
      default: begin
        if (!train_on) begin
          inv = inv_dev(var_tbl[ch]);
          norm_expect_q.push_back(make_result(
            norm_sample(v, avg_tbl[ch], inv, gain_tbl[ch], bias_tbl[ch]), ch, 1'b1));
        end else begin
          if (held_cnt < DEPTH) begin
            held[held_cnt] = v;
            held_cnt++;
            held_sum += v;
          end
          if (it.last && held_cnt != 0) begin
            n = held_cnt;
            q = held_sum / n;
            if ((held_sum % n) != 0 && held_sum < 0) q--;
            mu = q;
            acc = 0;
            for (int k = 0; k < n; k++) begin
              dm = (held[k] - mu < 0) ? mu - held[k] : held[k] - mu;
              acc += (dm * dm) >> 16;
            end
            acc /= n;
            vr = (acc > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : longint'(acc);
            avg_tbl[ch] = blend_running(avg_tbl[ch], mu);
            var_tbl[ch] = blend_running(var_tbl[ch], vr);
            inv = inv_dev(vr);
            for (int k = 0; k < n; k++)
              norm_expect_q.push_back(make_result(
                norm_sample(held[k], mu, inv, gain_tbl[ch], bias_tbl[ch]), ch, k + 1 == n));
            held_cnt = 0;
            held_sum = 0;
          end
        end
      end
    endcase
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      train_on = 1'b0;
      eps_q16  = EPS_RST;
      mom_q16  = MOM_RST;
      for (int i = 0; i < NCH; i++) begin
        gain_tbl[i] = 65536;
        bias_tbl[i] = 0;
        avg_tbl[i]  = 0;
        var_tbl[i]  = 65536;
      end
      held_cnt = 0;
      held_sum = 0;
      norm_expect_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE: train_on = cfg_data[0];
          CFG_EPS:  eps_q16 = cfg_data;
          CFG_MOM:  mom_q16 = cfg_data;
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (norm_expect_q.size() == 0) begin
          $error("result beat with nothing expected: normalized %0d channel %0d",
                 $signed(result.normalized), result.out_channel);
          failures++;
        end else begin
          want = norm_expect_q.pop_front();
          check_field("normalized", $signed(want.normalized), $signed(result.normalized));
          check_field("out_channel", want.out_channel, result.out_channel);
          check_field("out_last", want.out_last, result.out_last);
          check_field("new_running_mean", $signed(want.new_running_mean),
                      $signed(result.new_running_mean));
          check_field("new_running_variance", want.new_running_variance,
                      result.new_running_variance);
        end
      end
      if (item_valid && item_ready) predict_beat(item);
    end
    pending = norm_expect_q.size();
  end

endmodule

// ----- verif/tb.sv -----
module tb;
  import bn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any beat on either channel before the run is declared hung.
  localparam int HANG_LIMIT = 20000;
  // Quiet time allowed for the block to finish work that yields no result.
  localparam int SETTLE_CYCLES = 250;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  in_item_t    item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  out_item_t   result;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_MODE;
  logic [16:0] cfg_data = '0;

  int failures;
  int pending;
  int idle_cycles = 0;
  // While calm is set neither side inserts gaps or stalls.
  bit calm = 1'b0;

  always #1 clk = ~clk;

  batch_norm_forward i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bn_checker i_checker (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .pending(pending)
  );

  // The receiver stalls with a probability of about eight percent, unless calm.
  always @(posedge clk) begin
    result_ready <= calm || ($urandom_range(99) >= 8);
  end

  // Watchdog: any beat on either channel resets the count.
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("batch_norm_forward test failed");
        $finish;
      end
    end
  end

  // Presents one beat and holds it until it is accepted. The sender may
  // first drop valid; valid is left high afterwards so back-to-back beats
  // need no second assignment in the same step.
  task automatic send_beat(logic [2:0] cmd, int ch, logic [31:0] val, bit lst);
    if (!calm && $urandom_range(99) < 8) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_valid    <= 1'b1;
    item.command  <= cmd;
    item.channel  <= ch[5:0];
    item.value    <= val;
    item.last     <= lst;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  // Drops valid and waits until every expected result has come back, then
  // gives the block time to finish any batch bookkeeping that emits nothing.
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called once the block is idle.
  task automatic write_reg(logic [1:0] idx, logic [16:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Sample values: a mix of full-range words, extremes and small magnitudes
  // so that the normalised outputs are not always saturated.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: return -$urandom_range(0, 1 << 20);
      default: return $urandom_range(0, 1 << 22) - (1 << 21);
    endcase
  endfunction

  function automatic logic [2:0] pick_table_cmd();
    case ($urandom_range(3))
      0: return CMD_SCALE;
      1: return CMD_SHIFT;
      2: return CMD_MEAN;
      default: return CMD_VAR;
    endcase
  endfunction

  // One training batch of n samples, the last beat marked last. Now and then
  // the channel changes within the batch, which the block must tolerate.
  task automatic send_batch(int n);
    int ch;
    ch = $urandom_range(63);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(19) == 0) ch = $urandom_range(63);
      send_beat(CMD_SAMPLE, ch, pick_value(), k == n - 1);
    end
  endtask

  initial begin
    int sent;
    logic [16:0] eps_pick, mom_pick;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, inference mode with reset tables first: the extremes
    // of the sample word, then table loads that force saturation.
    send_beat(CMD_SAMPLE, 0, 32'h0000_0000, 1'b0);
    send_beat(CMD_SAMPLE, 0, 32'h7FFF_FFFF, 1'b1);
    send_beat(CMD_SAMPLE, 0, 32'h8000_0000, 1'b0);
    send_beat(CMD_SCALE, 5, 32'h8000_0000, 1'b0);
    send_beat(CMD_SHIFT, 5, 32'h7FFF_FFFF, 1'b0);
    send_beat(CMD_MEAN, 5, 32'h8000_0000, 1'b0);
    // A negative variance load is stored as zero.
    send_beat(CMD_VAR, 5, 32'hFFFF_FFFB, 1'b0);
    send_beat(CMD_SAMPLE, 5, 32'h7FFF_FFFF, 1'b1);
    send_beat(CMD_SAMPLE, 5, 32'h8000_0000, 1'b1);
    // Unused command codes are dropped without a result.
    send_beat(3'd5, 1, 32'h1234_5678, 1'b1);
    send_beat(3'd6, 2, 32'hFFFF_FFFF, 1'b0);
    send_beat(3'd7, 63, 32'h0, 1'b1);
    send_beat(CMD_SCALE, 63, 32'h0002_0000, 1'b0);
    send_beat(CMD_VAR, 63, 32'h0, 1'b0);
    send_beat(CMD_SAMPLE, 63, 32'h0001_8000, 1'b0);
    settle();

    // Zero radicand: zero variance with zero epsilon saturates the inverse deviation.
    write_reg(CFG_EPS, 17'd0);
    send_beat(CMD_SAMPLE, 63, 32'hFFFF_0000, 1'b1);
    send_beat(CMD_SAMPLE, 63, 32'h0000_0001, 1'b0);
    settle();

    // Training with a momentum above one, which is clamped to one.
    write_reg(CFG_EPS, 17'd65536);
    write_reg(CFG_MOM, 17'h1FFFF);
    write_reg(CFG_MODE, 17'd1);
    send_beat(CMD_SAMPLE, 3, 32'h0001_0000, 1'b0);
    send_beat(CMD_SAMPLE, 3, 32'h0003_0000, 1'b0);
    send_beat(CMD_SAMPLE, 3, 32'hFFFE_0000, 1'b1);
    // A batch of one sample has zero variance.
    send_beat(CMD_SAMPLE, 9, 32'h0005_0000, 1'b1);
    settle();

    // Random part, in phases that cycle through register settings, the
    // extremes among them. The third phase runs without any idling.
    sent = 0;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: eps_pick = 17'd0;
        1: eps_pick = 17'd65536;
        2: eps_pick = 17'd1;
        default: eps_pick = 17'($urandom_range(0, 131071));
      endcase
      case (phase % 3)
        0: mom_pick = 17'd0;
        1: mom_pick = 17'd65536;
        default: mom_pick = 17'($urandom_range(0, 131071));
      endcase
      calm = (phase == 2);
      write_reg(CFG_EPS, eps_pick);
      write_reg(CFG_MOM, mom_pick);
      write_reg(CFG_MODE, (phase % 2 == 1) ? 17'd1 : 17'd0);

      if (phase % 2 == 1) begin
        // Mode change mid-batch: the held samples survive inference work
        // and the batch closes once training resumes.
        send_beat(CMD_SAMPLE, 7, pick_value(), 1'b0);
        send_beat(CMD_SAMPLE, 7, pick_value(), 1'b0);
        settle();
        write_reg(CFG_MODE, 17'd0);
        send_beat(CMD_SAMPLE, 7, pick_value(), 1'b1);
        settle();
        write_reg(CFG_MODE, 17'd1);
        send_batch(3);
        // Overfull batch: samples past the buffer depth are dropped.
        if (phase == 3) begin
          send_batch(66);
          sent += 66;
        end
        while (sent < 60 * (phase + 1)) begin
          case ($urandom_range(19))
            0: begin
              send_beat(pick_table_cmd(), $urandom_range(63), pick_value(),
                        1'($urandom_range(1)));
              sent++;
            end
            1: begin
              send_beat(3'($urandom_range(5, 7)), $urandom_range(63), $urandom, 1'b1);
              sent++;
            end
            default: begin
              int n;
              n = ($urandom_range(29) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 8);
              send_batch(n);
              sent += n;
            end
          endcase
        end
      end else begin
        while (sent < 60 * (phase + 1)) begin
          case ($urandom_range(9))
            0, 1, 2: send_beat(pick_table_cmd(), $urandom_range(63), pick_value(),
                               1'($urandom_range(1)));
            3: send_beat(3'($urandom_range(5, 7)), $urandom_range(63), $urandom,
                         1'($urandom_range(1)));
            default: begin
              send_beat(CMD_SAMPLE, $urandom_range(63), pick_value(),
                        1'($urandom_range(1)));
            end
          endcase
          sent++;
        end
      end
      settle();
    end

    calm = 1'b0;
    if (failures == 0) begin
      $display("batch_norm_forward test passed");
    end else begin
      $display("batch_norm_forward test failed");
    end
    $finish;
  end

endmodule
